// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, operation and status codes, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_LIST       = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_PUSH_FRONT,
        PTR_PUSH_BACK,
        PTR_POP_FRONT,
        PTR_POP_BACK,
        PTR_CLEAR
    } t_ptr_op;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        t_ptr_op ptr_op;
        logic    wr_en;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        logic    out_from_mem;
        t_status out_status;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic list_last;
        logic out_free;
    } t_stat;

endpackage

// File: sv/deq_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::OP_W-1:0]          operation;
    logic signed [deq_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::DATA_W-1:0] value_out;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic                              last;

    modport source (output valid, output value_out, output status, output last,
                    input ready);
    modport sink   (input valid, input value_out, input status, input last,
                    output ready);
endinterface

// File: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes each request and sequences the memory reads of pops and lists.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  deq_pkg::t_op     i_operation,
    input  deq_pkg::t_stat   i_stat,
    output logic             o_ready,
    output deq_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_list, n_list;

    assign o_ready = (r_state == ST_IDLE) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_list  = r_list;
        o_cmd   = '0;
        o_cmd.ptr_op     = deq_pkg::PTR_HOLD;
        o_cmd.rd_sel     = deq_pkg::RD_FRONT;
        o_cmd.out_status = deq_pkg::STATUS_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    unique case (i_operation) inside
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = deq_pkg::STATUS_FULL;
                            end else begin
                                o_cmd.wr_en  = 1'b1;
                                o_cmd.ptr_op = (i_operation == deq_pkg::OP_PUSH_FRONT) ?
                                               deq_pkg::PTR_PUSH_FRONT :
                                               deq_pkg::PTR_PUSH_BACK;
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                if (i_operation == deq_pkg::OP_POP_FRONT) begin
                                    o_cmd.rd_sel = deq_pkg::RD_FRONT;
                                    o_cmd.ptr_op = deq_pkg::PTR_POP_FRONT;
                                end else begin
                                    o_cmd.rd_sel = deq_pkg::RD_BACK;
                                    o_cmd.ptr_op = deq_pkg::PTR_POP_BACK;
                                end
                                n_list  = 1'b0;
                                n_state = ST_READ;
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            o_cmd.ptr_op = deq_pkg::PTR_CLEAR;
                        end
                        deq_pkg::OP_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.rd_sel  = deq_pkg::RD_FRONT;
                                o_cmd.idx_clr = 1'b1;
                                n_list  = 1'b1;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    o_cmd.out_last     = !r_list || i_stat.list_last;
                    if (r_list && !i_stat.list_last) begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = deq_pkg::RD_NEXT;
                        o_cmd.idx_inc = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_list  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_list  <= n_list;
        end
    end

endmodule

// File: sv/deq_dpath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring storage, front pointer, element count, list index and the
// registered response.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    input  deq_pkg::t_cmd                     i_cmd,
    input  logic                              i_out_ready,
    output deq_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_value_out,
    output logic [deq_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [deq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [deq_pkg::DATA_W-1:0] r_rd_data;
    logic [AW-1:0]                     r_front;
    logic [CW-1:0]                     r_count;
    logic [AW-1:0]                     r_idx;
    logic [AW-1:0]                     front_m1;
    logic [AW-1:0]                     back_slot;
    logic [AW-1:0]                     last_slot;
    logic [AW-1:0]                     next_slot;
    logic [AW-1:0]                     wr_addr;
    logic [AW-1:0]                     rd_addr;
    logic                              r_out_valid;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign front_m1  = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign back_slot = wrap(r_front, r_count[AW-1:0]);
    assign last_slot = wrap(r_front, r_count[AW-1:0] - AW'(1));
    assign next_slot = wrap(r_front, r_idx + AW'(1));

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.list_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign wr_addr = (i_cmd.ptr_op == deq_pkg::PTR_PUSH_FRONT) ? front_m1 : back_slot;

    always_comb begin
        case (i_cmd.rd_sel)
            deq_pkg::RD_BACK: rd_addr = last_slot;
            deq_pkg::RD_NEXT: rd_addr = next_slot;
            default:          rd_addr = r_front;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            case (i_cmd.ptr_op)
                deq_pkg::PTR_PUSH_FRONT: begin
                    r_front <= front_m1;
                    r_count <= r_count + CW'(1);
                end
                deq_pkg::PTR_PUSH_BACK: r_count <= r_count + CW'(1);
                deq_pkg::PTR_POP_FRONT: begin
                    r_front <= wrap(r_front, AW'(1));
                    r_count <= r_count - CW'(1);
                end
                deq_pkg::PTR_POP_BACK: r_count <= r_count - CW'(1);
                deq_pkg::PTR_CLEAR: begin
                    r_front <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_value_out <= i_cmd.out_from_mem ? r_rd_data : '0;
            o_status    <= i_cmd.out_status;
            o_last      <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Element count exceeds the queue depth.");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !o_stat.full)
        else $error("Write issued while the queue is full.");
    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> !o_stat.empty)
        else $error("Read issued while the queue is empty.");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !i_cmd.out_load)
        else $error("Stalled response overwritten.");
`endif

endmodule

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words held in a ring buffer.
// ----------------------------------------------------------------------------
// Requests arrive on i_in (operation, value) and responses leave on o_out
// (value_out, status, last); both use a valid and ready handshake.
// A push, or a pop or list of an empty queue, is answered from the response
// register in the cycle after the request is accepted, one request per cycle while the receiver takes each response.
// A pop of a stored word reads the ring memory first, so its response passes
// through the read data register before the response register; the next
// request is taken once the controller is back in idle. A list of N words
// delivers one response per cycle while the receiver is ready, the last
// one marked, and holds the request side until that word is loaded; the
// single memory read port sets this pace. A clear gives no response.
// Reset empties the queue at once: front index and count go to zero, the
// memory contents are left as they are and no clearing pass is made.
// When the receiver stalls, the response register holds its word and no new
// request is accepted until that word is taken.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    deq_req_if.sink  i_in,
    deq_rsp_if.source o_out
);

    deq_pkg::t_cmd  cmd;
    deq_pkg::t_stat stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_operation (deq_pkg::t_op'(i_in.operation)),
        .i_stat      (stat),
        .o_ready     (i_in.ready),
        .o_cmd       (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_value_out (o_out.value_out),
        .o_status    (o_out.status),
        .o_last      (o_out.last)
    );

endmodule
